### rtl/ctg_pkg.sv
// Shared types, constants and tables for the coordinated-turn guidance step.
`timescale 1ns / 1ps

package ctg_pkg;

    localparam int unsigned CORDIC_N = 16;

    localparam logic [29:0] K_Q30        = 30'd652032874;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
    localparam logic [19:0] G_Q16        = 20'd642646;
    // ceil(2^24 / 100): exact floor(x / 100) for any 16-bit x
    localparam logic [17:0] RECIP_100    = 18'd167773;

    typedef enum logic [2:0] {
        REG_THROTTLE_MAX     = 3'd0,
        REG_THROTTLE_MIN     = 3'd1,
        REG_THROTTLE_NOMINAL = 3'd2,
        REG_ROLL_GAIN        = 3'd3,
        REG_CLIMB_GAIN       = 3'd4,
        REG_ROLL_LIMIT       = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_THR,
        ST_COS,
        ST_GC_LO,
        ST_GC_HI,
        ST_AT_INIT,
        ST_AT,
        ST_ROLL,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [15:0] throttle_max;
        logic [15:0] throttle_min;
        logic [15:0] throttle_nominal;
        logic [15:0] roll_gain;
        logic [15:0] climb_gain;
        logic [14:0] roll_limit;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       thr;
        logic       cos_iter;
        logic       gc_lo;
        logic       gc_hi;
        logic       at_init;
        logic       at_iter;
        logic       roll;
        logic       finish;
        logic [3:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

    function automatic logic [29:0] atan_tab(input logic [3:0] i);
        logic [29:0] r;
        case (i)
            4'd0:    r = 30'd843314857;
            4'd1:    r = 30'd497837829;
            4'd2:    r = 30'd263043837;
            4'd3:    r = 30'd133525159;
            4'd4:    r = 30'd67021687;
            4'd5:    r = 30'd33543516;
            4'd6:    r = 30'd16775851;
            4'd7:    r = 30'd8388437;
            4'd8:    r = 30'd4194283;
            4'd9:    r = 30'd2097149;
            4'd10:   r = 30'd1048576;
            4'd11:   r = 30'd524288;
            4'd12:   r = 30'd262144;
            4'd13:   r = 30'd131072;
            4'd14:   r = 30'd65536;
            default: r = 30'd32768;
        endcase
        return r;
    endfunction

endpackage

### rtl/ctg_ctrl.sv
// Controller state machine sequencing the guidance datapath.
`timescale 1ns / 1ps

module ctg_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_auto,
    input  ctg_pkg::sts_t   sts,
    output logic            in_ready,
    output ctg_pkg::cmd_t   cmd
);

    ctg_pkg::state_t state_reg, state_next;
    logic [3:0] iter_reg, iter_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctg_pkg::ST_IDLE;
            iter_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            ctg_pkg::ST_IDLE:
            begin
                if (in_valid && in_auto)
                begin
                    state_next = ctg_pkg::ST_MUL;
                end
            end
            ctg_pkg::ST_MUL:    state_next = ctg_pkg::ST_THR;
            ctg_pkg::ST_THR:
            begin
                state_next = ctg_pkg::ST_COS;
                iter_next  = 4'd0;
            end
            ctg_pkg::ST_COS:
            begin
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'd15)
                begin
                    state_next = ctg_pkg::ST_GC_LO;
                end
            end
            ctg_pkg::ST_GC_LO:  state_next = ctg_pkg::ST_GC_HI;
            ctg_pkg::ST_GC_HI:  state_next = ctg_pkg::ST_AT_INIT;
            ctg_pkg::ST_AT_INIT:
            begin
                state_next = ctg_pkg::ST_AT;
                iter_next  = 4'd0;
            end
            ctg_pkg::ST_AT:
            begin
                iter_next = iter_reg + 4'd1;
                if (iter_reg == 4'd15)
                begin
                    state_next = ctg_pkg::ST_ROLL;
                end
            end
            ctg_pkg::ST_ROLL:   state_next = ctg_pkg::ST_FIN;
            ctg_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = ctg_pkg::ST_IDLE;
                end
            end
            default:            state_next = ctg_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ctg_pkg::ST_IDLE);
        cmd          = '0;
        cmd.iter     = iter_reg;
        cmd.load     = in_ready && in_valid;
        cmd.mul      = (state_reg == ctg_pkg::ST_MUL);
        cmd.thr      = (state_reg == ctg_pkg::ST_THR);
        cmd.cos_iter = (state_reg == ctg_pkg::ST_COS);
        cmd.gc_lo    = (state_reg == ctg_pkg::ST_GC_LO);
        cmd.gc_hi    = (state_reg == ctg_pkg::ST_GC_HI);
        cmd.at_init  = (state_reg == ctg_pkg::ST_AT_INIT);
        cmd.at_iter  = (state_reg == ctg_pkg::ST_AT);
        cmd.roll     = (state_reg == ctg_pkg::ST_ROLL);
        cmd.finish   = (state_reg == ctg_pkg::ST_FIN) && sts.out_free;
    end

`ifndef NO_ASSERTIONS
    a_cos_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ctg_pkg::ST_COS && iter_reg == 4'd15) |=> state_reg == ctg_pkg::ST_GC_LO)
        else $error("cos iterations did not end after 16 steps");
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> sts.out_free)
        else $error("result written while output register busy");
    a_load_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && in_auto) |=> state_reg == ctg_pkg::ST_MUL)
        else $error("automatic beat not started");
    a_manual_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !in_auto) |=> state_reg == ctg_pkg::ST_IDLE)
        else $error("manual beat started work");
`endif

endmodule

### rtl/ctg_dp.sv
// Guidance datapath: throttle offset, climb product, CORDIC cosine and atan, roll limit.
`timescale 1ns / 1ps

module ctg_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctg_pkg::cfg_t      cfg,
    input  ctg_pkg::cmd_t      cmd,
    output ctg_pkg::sts_t      sts,
    input  logic               in_opcode,
    input  logic signed [15:0] in_turn,
    input  logic signed [15:0] in_climb,
    input  logic signed [15:0] in_req,
    input  logic        [15:0] in_gs,
    input  logic signed [15:0] in_pitch,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_roll,
    output logic signed [15:0] out_climb,
    output logic               out_cvalid,
    output logic        [15:0] out_thr
);

    logic               three_d_reg;
    logic signed [15:0] turn_reg, climb_reg, req_reg, pitch_reg;
    logic        [15:0] gs_reg;
    logic        [9:0]  step_reg;
    logic               range_neg_reg;
    logic signed [32:0] climb_p_reg, num_reg;
    logic signed [16:0] offset_reg;
    logic        [15:0] thr_reg;
    logic signed [15:0] climb_sp_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               cneg_reg;
    logic signed [55:0] acc_reg;
    logic signed [51:0] ax_reg, ay_reg;
    logic signed [33:0] az_reg;
    logic               den0_reg;
    logic        [47:0] mag_prod_reg;
    logic               zneg_reg;
    logic               out_valid_reg;
    logic signed [15:0] roll_out_reg, climb_out_reg;
    logic               cvalid_out_reg;
    logic        [15:0] thr_out_reg;

    // throttle step
    logic signed [16:0] range_s, rabs17, hi_s, lo_s;
    logic        [33:0] step_prod;
    logic signed [10:0] step_s, delta;
    logic signed [17:0] sum, thr_sum;
    logic signed [16:0] off_new;
    logic        [15:0] thr_sat;
    // climb
    logic signed [32:0] climb_p, q_t, num_p;
    logic signed [15:0] climb_sat;
    // cosine
    logic signed [16:0] pabs17;
    logic signed [34:0] a_s, t_s;
    logic signed [33:0] cxs, cys, ctab, cosv;
    logic        [35:0] prod_lo;
    logic signed [38:0] prod_hi;
    // atan
    logic signed [25:0] den, den_a;
    logic signed [33:0] num_a, half_s, zabs;
    logic signed [51:0] axs, ays;
    logic        [47:0] mag_prod;
    logic signed [19:0] roll_s, lim_s;

    always_comb
    begin
        range_s   = $signed({1'b0, cfg.throttle_max}) - $signed({1'b0, cfg.throttle_min});
        rabs17    = range_s[16] ? -range_s : range_s;
        step_prod = 34'(rabs17[15:0]) * 34'(ctg_pkg::RECIP_100);
        hi_s      = $signed({1'b0, cfg.throttle_max}) - $signed({1'b0, cfg.throttle_nominal});
        lo_s      = $signed({1'b0, cfg.throttle_min}) - $signed({1'b0, cfg.throttle_nominal});
        step_s    = range_neg_reg ? -$signed({1'b0, step_reg}) : $signed({1'b0, step_reg});
        if (req_reg > 16'sd0)
            delta = step_s;
        else if (req_reg < 16'sd0)
            delta = -step_s;
        else
            delta = 11'sd0;
        sum = {offset_reg[16], offset_reg} + {{7{delta[10]}}, delta};
        if (sum > $signed({hi_s[16], hi_s}))
            off_new = hi_s;
        else if (sum < $signed({lo_s[16], lo_s}))
            off_new = lo_s;
        else
            off_new = sum[16:0];
        thr_sum = $signed({2'b0, cfg.throttle_nominal}) + {off_new[16], off_new};
        if (thr_sum < 18'sd0)
            thr_sat = 16'd0;
        else if (thr_sum > 18'sd65535)
            thr_sat = 16'hFFFF;
        else
            thr_sat = thr_sum[15:0];

        climb_p = $signed({1'b0, cfg.climb_gain}) * climb_reg;
        q_t     = climb_p_reg[32] ? ((climb_p_reg + 33'sd4095) >>> 12) : (climb_p_reg >>> 12);
        if (q_t > 33'sd32767)
            climb_sat = 16'sh7FFF;
        else if (q_t < -33'sd32768)
            climb_sat = -16'sh8000;
        else
            climb_sat = q_t[15:0];
        num_p = turn_reg * $signed({1'b0, gs_reg});

        pabs17 = pitch_reg[15] ? -{pitch_reg[15], pitch_reg} : {pitch_reg[15], pitch_reg};
        a_s    = $signed({1'b0, pabs17, 17'b0});
        t_s    = $signed({3'b0, ctg_pkg::PI_Q30}) - a_s;
        if (t_s < 35'sd0)
            t_s = -t_s;

        cxs  = cx_reg >>> cmd.iter;
        cys  = cy_reg >>> cmd.iter;
        ctab = $signed({4'b0, ctg_pkg::atan_tab(cmd.iter)});
        cosv = cneg_reg ? -cx_reg : cx_reg;
        prod_lo = 36'(ctg_pkg::G_Q16) * 36'(cosv[15:0]);
        prod_hi = $signed({1'b0, ctg_pkg::G_Q16}) * $signed(cosv[33:16]);

        den    = acc_reg[55:30];
        den_a  = den[25] ? -den : den;
        num_a  = den[25] ? -{num_reg[32], num_reg} : {num_reg[32], num_reg};
        half_s = $signed({3'b0, ctg_pkg::HALF_PI_Q30});
        axs    = ax_reg >>> cmd.iter;
        ays    = ay_reg >>> cmd.iter;

        zabs     = az_reg[33] ? -az_reg : az_reg;
        mag_prod = 48'(cfg.roll_gain) * 48'(zabs[31:0]);
        roll_s   = zneg_reg ? $signed({1'b0, mag_prod_reg[47:29]})
                            : -$signed({1'b0, mag_prod_reg[47:29]});
        lim_s    = $signed({5'b0, cfg.roll_limit});
        if (roll_s > lim_s)
            roll_s = lim_s;
        if (roll_s < -lim_s)
            roll_s = -lim_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= 17'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.thr)
                offset_reg <= off_new;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            three_d_reg <= in_opcode;
            turn_reg    <= in_turn;
            climb_reg   <= in_climb;
            req_reg     <= in_req;
            gs_reg      <= in_gs;
            pitch_reg   <= in_pitch;
        end
        if (cmd.mul)
        begin
            step_reg      <= step_prod[33:24];
            range_neg_reg <= range_s[16];
            climb_p_reg   <= climb_p;
            num_reg       <= num_p;
            cx_reg        <= $signed({4'b0, ctg_pkg::K_Q30});
            cy_reg        <= 34'sd0;
            if (a_s > $signed({4'b0, ctg_pkg::HALF_PI_Q30}))
            begin
                cz_reg   <= t_s[33:0];
                cneg_reg <= 1'b1;
            end
            else
            begin
                cz_reg   <= a_s[33:0];
                cneg_reg <= 1'b0;
            end
        end
        if (cmd.thr)
        begin
            thr_reg      <= thr_sat;
            climb_sp_reg <= three_d_reg ? climb_sat : 16'sd0;
        end
        if (cmd.cos_iter)
        begin
            if (!cz_reg[33])
            begin
                cx_reg <= cx_reg - cys;
                cy_reg <= cy_reg + cxs;
                cz_reg <= cz_reg - ctab;
            end
            else
            begin
                cx_reg <= cx_reg + cys;
                cy_reg <= cy_reg - cxs;
                cz_reg <= cz_reg + ctab;
            end
        end
        if (cmd.gc_lo)
            acc_reg <= $signed({20'b0, prod_lo});
        if (cmd.gc_hi)
            acc_reg <= acc_reg + 56'($signed({prod_hi, 16'b0}));
        if (cmd.at_init)
        begin
            ax_reg   <= $signed({{12{den_a[25]}}, den_a, 14'b0});
            ay_reg   <= $signed({{4{num_a[33]}}, num_a, 14'b0});
            den0_reg <= (den == 26'sd0);
            if (den != 26'sd0)
                az_reg <= 34'sd0;
            else if (num_a > 34'sd0)
                az_reg <= half_s;
            else if (num_a < 34'sd0)
                az_reg <= -half_s;
            else
                az_reg <= 34'sd0;
        end
        if (cmd.at_iter && !den0_reg)
        begin
            if (!ay_reg[51])
            begin
                ax_reg <= ax_reg + ays;
                ay_reg <= ay_reg - axs;
                az_reg <= az_reg + ctab;
            end
            else
            begin
                ax_reg <= ax_reg - ays;
                ay_reg <= ay_reg + axs;
                az_reg <= az_reg - ctab;
            end
        end
        if (cmd.roll)
        begin
            mag_prod_reg <= mag_prod;
            zneg_reg     <= az_reg[33];
        end
        if (cmd.finish)
        begin
            roll_out_reg   <= roll_s[15:0];
            climb_out_reg  <= climb_sp_reg;
            cvalid_out_reg <= three_d_reg;
            thr_out_reg    <= thr_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_roll     = roll_out_reg;
    assign out_climb    = climb_out_reg;
    assign out_cvalid   = cvalid_out_reg;
    assign out_thr      = thr_out_reg;

endmodule

### rtl/coordinated_turn_guidance_step.sv
// Top level: APB register file, stream ports, controller and datapath.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata: turn, climb, request, speed, pitch; tuser: op, auto
//  m_*       out  m_tvalid/m_tready   tdata: roll, climb, throttle; tuser: climb_valid
//  apb       in   psel/penable        six config registers at 4*i
//
// An automatic beat holds s_tready low from acceptance through two 16-step CORDIC
// loops (cosine, then atan) on one shared sequencer, until its result is written.
// Manual beats are taken without leaving idle and give no result.
// Reset clears the throttle offset and loads the register defaults.
// A result waiting on m_tready holds in the output register; the next beat is
// already taken and stalls only at its own final step.
`timescale 1ns / 1ps

module coordinated_turn_guidance_step
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // turn_rate, climb_rate, throttle_request, gnd_speed, pitch_angle
    input  logic [1:0]  s_tuser,   // opcode, auto_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // roll_setpoint, climb_setpoint, throttle_cmd
    output logic        m_tuser,   // climb_valid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ctg_pkg::cfg_t cfg_reg;
    ctg_pkg::cmd_t cmd;
    ctg_pkg::sts_t sts;
    logic          wr_en;
    logic signed [15:0] roll, climb_sp;
    logic          cvalid;
    logic [15:0]   thr;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.throttle_max     <= 16'd52429;
            cfg_reg.throttle_min     <= 16'd26214;
            cfg_reg.throttle_nominal <= 16'd39322;
            cfg_reg.roll_gain        <= 16'd4096;
            cfg_reg.climb_gain       <= 16'd4096;
            cfg_reg.roll_limit       <= 15'd5719;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                ctg_pkg::REG_THROTTLE_MAX:     cfg_reg.throttle_max     <= pwdata[15:0];
                ctg_pkg::REG_THROTTLE_MIN:     cfg_reg.throttle_min     <= pwdata[15:0];
                ctg_pkg::REG_THROTTLE_NOMINAL: cfg_reg.throttle_nominal <= pwdata[15:0];
                ctg_pkg::REG_ROLL_GAIN:        cfg_reg.roll_gain        <= pwdata[15:0];
                ctg_pkg::REG_CLIMB_GAIN:       cfg_reg.climb_gain       <= pwdata[15:0];
                ctg_pkg::REG_ROLL_LIMIT:       cfg_reg.roll_limit       <= pwdata[14:0];
                default:;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            ctg_pkg::REG_THROTTLE_MAX:     prdata = {16'd0, cfg_reg.throttle_max};
            ctg_pkg::REG_THROTTLE_MIN:     prdata = {16'd0, cfg_reg.throttle_min};
            ctg_pkg::REG_THROTTLE_NOMINAL: prdata = {16'd0, cfg_reg.throttle_nominal};
            ctg_pkg::REG_ROLL_GAIN:        prdata = {16'd0, cfg_reg.roll_gain};
            ctg_pkg::REG_CLIMB_GAIN:       prdata = {16'd0, cfg_reg.climb_gain};
            ctg_pkg::REG_ROLL_LIMIT:       prdata = {17'd0, cfg_reg.roll_limit};
            default:                       prdata = 32'd0;
        endcase
    end

    ctg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_auto  (s_tuser[1]),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    ctg_dp u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .sts        (sts),
        .in_opcode  (s_tuser[0]),
        .in_turn    ($signed(s_tdata[15:0])),
        .in_climb   ($signed(s_tdata[31:16])),
        .in_req     ($signed(s_tdata[47:32])),
        .in_gs      (s_tdata[63:48]),
        .in_pitch   ($signed(s_tdata[79:64])),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_roll   (roll),
        .out_climb  (climb_sp),
        .out_cvalid (cvalid),
        .out_thr    (thr)
    );

    assign m_tdata = {thr, climb_sp, roll};
    assign m_tuser = cvalid;

endmodule

### test/tb_top.sv
// Self-checking testbench for the coordinated-turn guidance step.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ATAN_TAB [16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
        131072, 65536, 32768};

    typedef struct packed {
        logic [15:0] roll;
        logic [15:0] climb;
        logic        climb_valid;
        logic [15:0] throttle;
    } guidance_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    coordinated_turn_guidance_step DUT (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    int cfg_max, cfg_min, cfg_nom, cfg_rgain, cfg_cgain, cfg_rlim;
    int thr_offset;
    guidance_t setpoint_q[$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int idle_pct = 34;
    int watchdog = 0;

    function automatic longint asr_l(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint pitch_cos(int theta);
        longint a, x, y, z, xs, ys;
        bit neg;
        a = longint'(theta < 0 ? -theta : theta) * 131072;
        neg = 0;
        x = ctg_pkg::K_Q30;
        y = 0;
        if (a > longint'(ctg_pkg::HALF_PI_Q30))
        begin
            a = longint'(ctg_pkg::PI_Q30) - a;
            if (a < 0) a = -a;
            neg = 1;
        end
        z = a;
        for (int i = 0; i < 16; i++)
        begin
            xs = asr_l(x, i);
            ys = asr_l(y, i);
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
            else
            begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
        end
        return neg ? -x : x;
    endfunction

    function automatic longint turn_atan(longint num, longint den);
        longint x, y, z, xs, ys;
        z = 0;
        if (den < 0)
        begin
            den = -den; num = -num;
        end
        if (den == 0)
            return num > 0 ? longint'(ctg_pkg::HALF_PI_Q30)
                           : (num < 0 ? -longint'(ctg_pkg::HALF_PI_Q30) : 0);
        x = den * 16384;
        y = num * 16384;
        for (int i = 0; i < 16; i++)
        begin
            xs = asr_l(x, i);
            ys = asr_l(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
            else
            begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic void predict_guidance(logic op, logic auto_m, logic [15:0] turn,
        logic [15:0] climb, logic [15:0] req, logic [15:0] gs, logic [15:0] pitch);
        guidance_t r;
        int hi, lo, dir, thr, p, q;
        longint den, z, mag, roll;
        if (!auto_m) return;
        hi = cfg_max - cfg_nom;
        lo = cfg_min - cfg_nom;
        dir = ($signed(req) > 0) - ($signed(req) < 0);
        thr_offset += dir * ((cfg_max - cfg_min) / 100);
        if (thr_offset > hi) thr_offset = hi;
        else if (thr_offset < lo) thr_offset = lo;
        thr = cfg_nom + thr_offset;
        if (thr < 0) thr = 0;
        if (thr > 65535) thr = 65535;
        q = 0;
        if (op)
        begin
            p = cfg_cgain * int'($signed(climb));
            q = p >= 0 ? p / 4096 : -((-p) / 4096);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
        end
        den = asr_l(longint'(ctg_pkg::G_Q16) * pitch_cos(int'($signed(pitch))), 30);
        z = turn_atan(longint'($signed(turn)) * longint'(gs), den);
        mag = (longint'(cfg_rgain) * (z < 0 ? -z : z)) >>> 29;
        roll = z >= 0 ? -mag : mag;
        if (roll > cfg_rlim) roll = cfg_rlim;
        if (roll < -cfg_rlim) roll = -cfg_rlim;
        r.roll = roll[15:0];
        r.climb = q[15:0];
        r.climb_valid = op;
        r.throttle = thr[15:0];
        setpoint_q.push_back(r);
    endfunction

    task automatic write_reg(ctg_pkg::reg_idx_t idx, int value);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            ctg_pkg::REG_THROTTLE_MAX:     cfg_max = value & 16'hFFFF;
            ctg_pkg::REG_THROTTLE_MIN:     cfg_min = value & 16'hFFFF;
            ctg_pkg::REG_THROTTLE_NOMINAL: cfg_nom = value & 16'hFFFF;
            ctg_pkg::REG_ROLL_GAIN:        cfg_rgain = value & 16'hFFFF;
            ctg_pkg::REG_CLIMB_GAIN:       cfg_cgain = value & 16'hFFFF;
            default:                       cfg_rlim = value & 15'h7FFF;
        endcase
    endtask

    task automatic send_tick(logic op, logic auto_m, logic [15:0] turn, logic [15:0] climb,
        logic [15:0] req, logic [15:0] gs, logic [15:0] pitch);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {pitch, gs, req, climb, turn};
        s_tuser <= {auto_m, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_guidance(op, auto_m, turn, climb, req, gs, pitch);
        n_items++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (setpoint_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_random(int n, bit narrow);
        logic [15:0] t, g;
        for (int i = 0; i < n; i++)
        begin
            t = 16'($urandom);
            g = 16'($urandom);
            if (narrow && $urandom_range(1))
            begin
                t = 16'($signed($urandom_range(0, 512)) - 256);
                g = 16'($urandom_range(0, 8000));
            end
            send_tick(1'($urandom), $urandom_range(9) != 0, t, 16'($urandom),
                16'($urandom), g, 16'($urandom));
        end
    endtask

    task automatic test_directed();
        send_tick(0, 0, 16'h7FFF, 0, 1, 16'hFFFF, 0);
        send_tick(0, 1, 0, 0, 0, 0, 0);
        send_tick(1, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF);
        send_tick(1, 1, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h8000);
        send_tick(1, 1, 16'h0100, 16'h0200, 1, 16'h0A00, 16'd12868);
        send_tick(1, 1, 16'hFF00, 16'hFE00, 16'hFFFF, 16'h0A00, -16'sd12868);
        send_tick(0, 1, 16'h0100, 0, 1, 16'h1000, 16'd25736);
        send_tick(0, 1, 16'h0100, 0, 1, 16'h1000, 16'd12867);
        send_tick(0, 1, 0, 0, 1, 16'h1000, 16'd12868);
        send_tick(0, 1, 16'h0040, 0, 0, 16'h0800, 16'd20000);
        for (int i = 0; i < 6; i++)
            send_tick(1, 1, 16'h0080, 16'h4000, 16'h0001, 16'h2000, 0);
        for (int i = 0; i < 6; i++)
            send_tick(1, 0, 16'h0080, 16'h4000, 16'h8001, 16'h2000, 0);
        drain();
    endtask

    task automatic test_config_sweep();
        write_reg(ctg_pkg::REG_THROTTLE_MAX, 65535);
        write_reg(ctg_pkg::REG_THROTTLE_MIN, 0);
        write_reg(ctg_pkg::REG_THROTTLE_NOMINAL, 65535);
        write_reg(ctg_pkg::REG_ROLL_GAIN, 65535);
        write_reg(ctg_pkg::REG_CLIMB_GAIN, 65535);
        write_reg(ctg_pkg::REG_ROLL_LIMIT, 32767);
        send_random(150, 1);
        drain();
        write_reg(ctg_pkg::REG_THROTTLE_MAX, 1000);
        write_reg(ctg_pkg::REG_THROTTLE_MIN, 60000);
        write_reg(ctg_pkg::REG_THROTTLE_NOMINAL, 0);
        write_reg(ctg_pkg::REG_ROLL_GAIN, 0);
        write_reg(ctg_pkg::REG_CLIMB_GAIN, 0);
        write_reg(ctg_pkg::REG_ROLL_LIMIT, 0);
        send_random(100, 1);
        drain();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(ctg_pkg::REG_THROTTLE_MAX, $urandom_range(65535));
            write_reg(ctg_pkg::REG_THROTTLE_MIN, $urandom_range(65535));
            write_reg(ctg_pkg::REG_THROTTLE_NOMINAL, $urandom_range(65535));
            write_reg(ctg_pkg::REG_ROLL_GAIN, $urandom_range(65535));
            write_reg(ctg_pkg::REG_CLIMB_GAIN, $urandom_range(65535));
            write_reg(ctg_pkg::REG_ROLL_LIMIT, $urandom_range(32767));
            idle_pct = (phase == 3) ? 0 : 34;
            send_random(130, 1);
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        guidance_t got, want;
        m_tready <= (idle_pct == 0) || ($urandom_range(99) >= 34);
        if (m_tvalid && m_tready)
        begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tuser, m_tdata[47:32]};
            n_results++;
            if (setpoint_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected beat: actual %h", $time, got);
            end
            else
            begin
                want = setpoint_q.pop_front();
                if (got.roll !== want.roll || got.climb !== want.climb ||
                    got.climb_valid !== want.climb_valid || got.throttle !== want.throttle)
                begin
                    errors++;
                    $display("%0t mismatch: expected roll %h climb %h cv %b thr %h,",
                        $time, want.roll, want.climb, want.climb_valid, want.throttle);
                    $display("    actual roll %h climb %h cv %b thr %h",
                        got.roll, got.climb, got.climb_valid, got.throttle);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) watchdog <= 0;
        else watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        cfg_max = 52429; cfg_min = 26214; cfg_nom = 39322;
        cfg_rgain = 4096; cfg_cgain = 4096; cfg_rlim = 5719;
        thr_offset = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random();
        drain();
        $display("Covered %0d ticks and %0d setpoint beats over eleven register settings,",
            n_items, n_results);
        $display("including throttle clamps, min above max, and pitch near +-pi/2.");
        if (errors == 0 && setpoint_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
